FILE: rtl/core/dhb_pkg.sv
// shared types, codes and the move pattern table for the dual h-bridge controller
`timescale 1ns / 1ps

package dhb_pkg;

  localparam int DHB_NUM_MOVES   = 12;
  localparam int DHB_TIMER_WIDTH = 16;

  // speed * ratio fits in this many signed bits
  localparam int DHB_PROD_W = 28;

  // duty = floor(p / 1000) for 0 <= p < 256000 is (p * DHB_RECIP) >> DHB_RECIP_SHIFT
  localparam int            DHB_RECIP_SHIFT = 28;
  localparam logic [18:0]   DHB_RECIP       = 19'd268436;
  localparam int            DHB_DUTY_LIMIT  = 256000;

  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_MOVE    = 3'd1;
  localparam logic [2:0] ACT_OFF     = 3'd2;
  localparam logic [2:0] ACT_UPDATE  = 3'd3;
  localparam logic [2:0] ACT_REAPPLY = 3'd4;

  localparam logic [2:0] CFG_LEFT_RATIO  = 3'd0;
  localparam logic [2:0] CFG_RIGHT_RATIO = 3'd1;
  localparam logic [2:0] CFG_LEFT_MODE   = 3'd2;
  localparam logic [2:0] CFG_RIGHT_MODE  = 3'd3;
  localparam logic [2:0] CFG_BLINK       = 3'd4;

  localparam logic [3:0] MOVE_OFF = 4'd0;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         move_kind;
    logic signed [15:0] speed;
    logic [15:0]        duration_ms;
  } in_word_t;

  typedef struct packed {
    logic [7:0] left_ahead;
    logic [7:0] left_back;
    logic [7:0] left_enable;
    logic [7:0] right_ahead;
    logic [7:0] right_back;
    logic [7:0] right_enable;
    logic       moving;
    logic [3:0] current_move;
  } out_word_t;

  // bits: {left ahead, left back, right ahead, right back}
  function automatic logic [3:0] move_bits(input logic [3:0] kind);
    logic [3:0] bits;
    case (kind)
      4'd0:    bits = 4'b0000;
      4'd1:    bits = 4'b1010;
      4'd2:    bits = 4'b0101;
      4'd3:    bits = 4'b1111;
      4'd4:    bits = 4'b0110;
      4'd5:    bits = 4'b1001;
      4'd6:    bits = 4'b1110;
      4'd7:    bits = 4'b1011;
      4'd8:    bits = 4'b1101;
      4'd9:    bits = 4'b0111;
      4'd10:   bits = 4'b1010;
      4'd11:   bits = 4'b1010;
      default: bits = 4'b0000;
    endcase
    return bits;
  endfunction

endpackage

FILE: rtl/core/dhb_duty.sv
// scaled product to clamped 8-bit duty, divide by 1000 through a reciprocal
`timescale 1ns / 1ps

module dhb_duty (
  input  logic signed [dhb_pkg::DHB_PROD_W-1:0] prod,
  output logic [7:0]                            duty
);
  import dhb_pkg::*;

  logic [17:0] p_lo;
  logic [36:0] q_full;

  assign p_lo   = prod[17:0];
  assign q_full = 37'(p_lo) * 37'(DHB_RECIP);

  always_comb begin
    if (prod < 0) begin
      duty = 8'd0;
    end else if (prod >= DHB_PROD_W'(DHB_DUTY_LIMIT)) begin
      duty = 8'd255;
    end else begin
      duty = q_full[DHB_RECIP_SHIFT+7:DHB_RECIP_SHIFT];
    end
  end

endmodule

FILE: rtl/core/dual_h_bridge_move_controller_core.sv
// top level of the dual h-bridge move controller: input stage, state update, output register
//
// Takes one word per cycle unless the output stalls (move, off, speed update, reapply or
// a 1 ms tick) and returns one result word per input word. The first stage registers the
// word together with speed * ratio for both motors (one 16x12 multiply each); the second
// stage divides by 1000 through a constant reciprocal, updates the timers and levels and
// loads the output register. in_ready follows out_ready within the cycle, so a stalled
// output holds at most one word in each stage. cfg_ready is always high; configuration is
// to be written only while no word is in flight, which the block does not enforce.
`timescale 1ns / 1ps

module dual_h_bridge_move_controller_core #(
  parameter int TIMER_WIDTH = dhb_pkg::DHB_TIMER_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dhb_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dhb_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import dhb_pkg::*;

  localparam int XW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
  localparam logic [XW-1:0] TMAX_X = XW'({TIMER_WIDTH{1'b1}});

  typedef logic [TIMER_WIDTH-1:0] timer_t;

  function automatic timer_t sat_timer(input logic [15:0] v);
    logic [XW-1:0] ext;
    ext = XW'(v);
    if (ext > TMAX_X) begin
      ext = TMAX_X;
    end
    return ext[TIMER_WIDTH-1:0];
  endfunction

  // configuration
  logic [11:0] ratio_r [2];
  logic [1:0]  mode_r;
  logic [15:0] blink_period_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r[0]     <= 12'd1000;
      ratio_r[1]     <= 12'd1000;
      mode_r         <= 2'b11;
      blink_period_r <= 16'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LEFT_RATIO:  ratio_r[0]     <= cfg_data[11:0];
        CFG_RIGHT_RATIO: ratio_r[1]     <= cfg_data[11:0];
        CFG_LEFT_MODE:   mode_r[0]      <= cfg_data[0];
        CFG_RIGHT_MODE:  mode_r[1]      <= cfg_data[0];
        CFG_BLINK:       blink_period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // state
  logic [3:0]  held_move_r, held_move_nxt;
  logic [15:0] held_speed_r, held_speed_nxt;
  timer_t      off_cd_r, off_cd_nxt;
  timer_t      blink_cd_r [2];
  timer_t      blink_cd_nxt [2];
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  ahead_r [2];
  logic [7:0]  ahead_nxt [2];
  logic [7:0]  back_r [2];
  logic [7:0]  back_nxt [2];
  logic [7:0]  en_r [2];
  logic [7:0]  en_nxt [2];
  logic [1:0]  active_r, active_nxt;

  // input stage
  logic                          a_valid_r;
  logic [2:0]                    a_action_r;
  logic [3:0]                    a_kind_r;
  logic [15:0]                   a_speed_r;
  logic [15:0]                   a_dur_r;
  logic signed [DHB_PROD_W-1:0]  a_prod_r [2];
  logic                          a_adv;
  logic signed [15:0]            eff_speed;
  logic signed [28:0]            prod_full [2];

  logic      out_valid_r;
  out_word_t out_data_r, out_data_nxt;

  assign a_adv    = a_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !a_valid_r || a_adv;

  // reapply uses the held speed as it stands once the word ahead has been applied
  always_comb begin
    if (in_data.action == ACT_REAPPLY) begin
      if (a_valid_r && (a_action_r == ACT_MOVE || a_action_r == ACT_UPDATE)) begin
        eff_speed = $signed(a_speed_r);
      end else begin
        eff_speed = $signed(held_speed_r);
      end
    end else begin
      eff_speed = in_data.speed;
    end
  end

  assign prod_full[0] = eff_speed * $signed({1'b0, ratio_r[0]});
  assign prod_full[1] = eff_speed * $signed({1'b0, ratio_r[1]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_valid_r <= 1'b1;
    end else if (a_adv) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_action_r  <= in_data.action;
      a_kind_r    <= in_data.move_kind;
      a_speed_r   <= in_data.speed;
      a_dur_r     <= in_data.duration_ms;
      a_prod_r[0] <= prod_full[0][DHB_PROD_W-1:0];
      a_prod_r[1] <= prod_full[1][DHB_PROD_W-1:0];
    end
  end

  // duty scaling
  logic [7:0] duty [2];

  dhb_duty u_duty_left (
    .prod (a_prod_r[0]),
    .duty (duty[0])
  );

  dhb_duty u_duty_right (
    .prod (a_prod_r[1]),
    .duty (duty[1])
  );

  // state update
  always_comb begin
    logic [3:0]  kind;
    logic [3:0]  bits;
    logic        do_write;
    logic        do_off;
    logic [15:0] per;
    timer_t      reload;
    logic        ba;
    logic        bb;
    logic [7:0]  d;
    logic [7:0]  ga;
    logic [7:0]  gb;
    logic [7:0]  ge;

    held_move_nxt  = held_move_r;
    held_speed_nxt = held_speed_r;
    off_cd_nxt     = off_cd_r;
    phase_nxt      = phase_r;
    active_nxt     = active_r;
    for (int m = 0; m < 2; m++) begin
      blink_cd_nxt[m] = blink_cd_r[m];
      ahead_nxt[m]    = ahead_r[m];
      back_nxt[m]     = back_r[m];
      en_nxt[m]       = en_r[m];
    end

    per    = (blink_period_r == 16'd0) ? 16'd1 : blink_period_r;
    reload = sat_timer(per);

    kind     = MOVE_OFF;
    do_write = 1'b0;
    do_off   = 1'b0;
    ba       = 1'b0;
    bb       = 1'b0;
    d        = 8'd0;
    ga       = 8'd0;
    gb       = 8'd0;
    ge       = 8'd0;

    if (a_adv) begin
      case (a_action_r)
        ACT_TICK: begin
          if (off_cd_r != '0) begin
            off_cd_nxt = off_cd_r - 1'b1;
            if (off_cd_nxt == '0) begin
              do_off = 1'b1;
            end
          end
        end
        ACT_MOVE: begin
          kind           = (a_kind_r < 4'(DHB_NUM_MOVES)) ? a_kind_r : MOVE_OFF;
          do_write       = 1'b1;
          held_speed_nxt = a_speed_r;
          off_cd_nxt     = sat_timer(a_dur_r);
        end
        ACT_OFF: begin
          do_off = 1'b1;
        end
        ACT_UPDATE: begin
          kind           = held_move_r;
          do_write       = 1'b1;
          held_speed_nxt = a_speed_r;
          off_cd_nxt     = '0;
        end
        ACT_REAPPLY: begin
          kind       = held_move_r;
          do_write   = 1'b1;
          off_cd_nxt = '0;
        end
        default: ;
      endcase
    end

    bits = move_bits(kind);
    if (do_write || do_off) begin
      held_move_nxt = do_off ? MOVE_OFF : kind;
      if (do_off) begin
        off_cd_nxt = '0;
      end
      for (int m = 0; m < 2; m++) begin
        ba = do_off ? 1'b0 : bits[3 - 2 * m];
        bb = do_off ? 1'b0 : bits[2 - 2 * m];
        d  = do_off ? 8'd0 : duty[m];
        if (mode_r[m]) begin
          ahead_nxt[m] = {7'd0, ba};
          back_nxt[m]  = {7'd0, bb};
          en_nxt[m]    = d;
        end else begin
          ahead_nxt[m] = ba ? d : 8'd0;
          back_nxt[m]  = bb ? d : 8'd0;
          en_nxt[m]    = 8'd0;
        end
        phase_nxt[m]    = 1'b1;
        active_nxt[m]   = ba | bb;
        blink_cd_nxt[m] = (ba && bb) ? reload : '0;
      end
    end

    if (a_adv && a_action_r == ACT_TICK) begin
      for (int m = 0; m < 2; m++) begin
        if (blink_cd_nxt[m] != '0) begin
          blink_cd_nxt[m] = blink_cd_nxt[m] - 1'b1;
          if (blink_cd_nxt[m] == '0) begin
            phase_nxt[m]    = ~phase_nxt[m];
            blink_cd_nxt[m] = reload;
          end
        end
      end
    end

    // result word from the updated levels, gated by blink phase
    out_data_nxt = '0;
    for (int m = 0; m < 2; m++) begin
      ga = ahead_nxt[m];
      gb = back_nxt[m];
      ge = en_nxt[m];
      if (!phase_nxt[m]) begin
        if (mode_r[m]) begin
          ge = 8'd0;
        end else begin
          ga = 8'd0;
          gb = 8'd0;
        end
      end
      if (m == 0) begin
        out_data_nxt.left_ahead  = ga;
        out_data_nxt.left_back   = gb;
        out_data_nxt.left_enable = ge;
      end else begin
        out_data_nxt.right_ahead  = ga;
        out_data_nxt.right_back   = gb;
        out_data_nxt.right_enable = ge;
      end
    end
    out_data_nxt.moving       = |active_nxt;
    out_data_nxt.current_move = held_move_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_move_r  <= MOVE_OFF;
      held_speed_r <= 16'd0;
      off_cd_r     <= '0;
      phase_r      <= 2'b00;
      active_r     <= 2'b00;
      for (int m = 0; m < 2; m++) begin
        blink_cd_r[m] <= '0;
        ahead_r[m]    <= 8'd0;
        back_r[m]     <= 8'd0;
        en_r[m]       <= 8'd0;
      end
    end else begin
      held_move_r  <= held_move_nxt;
      held_speed_r <= held_speed_nxt;
      off_cd_r     <= off_cd_nxt;
      phase_r      <= phase_nxt;
      active_r     <= active_nxt;
      for (int m = 0; m < 2; m++) begin
        blink_cd_r[m] <= blink_cd_nxt[m];
        ahead_r[m]    <= ahead_nxt[m];
        back_r[m]     <= back_nxt[m];
        en_r[m]       <= en_nxt[m];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: tb/sv/dhb_move_checker.sv
// move controller checker: predicts each result word and compares it with the block's output
`timescale 1ns / 1ps

module dhb_move_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  dhb_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  dhb_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 mismatches,
  output int                 awaited
);
  import dhb_pkg::*;

  // {left ahead, left back, right ahead, right back}
  localparam logic [3:0] MOVE_PINS [DHB_NUM_MOVES] = '{
    4'b0000, 4'b1010, 4'b0101, 4'b1111, 4'b0110, 4'b1001,
    4'b1110, 4'b1011, 4'b1101, 4'b0111, 4'b1010, 4'b1010
  };

  logic [11:0] ratio [2];
  logic        enable_mode [2];
  logic [15:0] blink_period;

  logic [3:0]         held_move;
  logic signed [15:0] held_speed;
  logic [15:0]        off_left;
  logic [15:0]        blink_left [2];
  logic               drive_on [2];
  logic [7:0]         ahead_lvl [2];
  logic [7:0]         back_lvl [2];
  logic [7:0]         enable_lvl [2];
  logic               active [2];

  out_word_t lines_due [$];
  int        results_seen;

  initial begin
    mismatches   = 0;
    awaited      = 0;
    results_seen = 0;
  end

  function automatic void clear_state();
    ratio[0]        = 12'd1000;
    ratio[1]        = 12'd1000;
    enable_mode[0]  = 1'b1;
    enable_mode[1]  = 1'b1;
    blink_period    = 16'd100;
    held_move       = MOVE_OFF;
    held_speed      = '0;
    off_left        = '0;
    for (int m = 0; m < 2; m++) begin
      blink_left[m] = '0;
      drive_on[m]   = 1'b0;
      ahead_lvl[m]  = '0;
      back_lvl[m]   = '0;
      enable_lvl[m] = '0;
      active[m]     = 1'b0;
    end
  endfunction

  function automatic logic [15:0] blink_reload();
    return (blink_period == 16'd0) ? 16'd1 : blink_period;
  endfunction

  function automatic logic [7:0] duty_of(logic signed [15:0] s, logic [11:0] r);
    longint p;
    p = (longint'(s) * longint'(r)) / 1000;
    if (p < 0) return 8'd0;
    if (p > 255) return 8'd255;
    return p[7:0];
  endfunction

  function automatic void load_motor(int m, logic a, logic b, logic signed [15:0] s);
    logic [7:0] duty;
    duty = duty_of(s, ratio[m]);
    if (enable_mode[m]) begin
      ahead_lvl[m]  = {7'd0, a};
      back_lvl[m]   = {7'd0, b};
      enable_lvl[m] = duty;
    end else begin
      ahead_lvl[m]  = a ? duty : 8'd0;
      back_lvl[m]   = b ? duty : 8'd0;
      enable_lvl[m] = 8'd0;
    end
    drive_on[m]   = 1'b1;
    active[m]     = a | b;
    blink_left[m] = (a && b) ? blink_reload() : 16'd0;
  endfunction

  function automatic void start_move(logic [3:0] kind, logic signed [15:0] s,
                                     logic [15:0] dur);
    logic [3:0] k;
    logic [3:0] pins;
    k = (kind >= DHB_NUM_MOVES) ? MOVE_OFF : kind;
    pins = MOVE_PINS[k];
    held_move  = k;
    held_speed = s;
    load_motor(0, pins[3], pins[2], s);
    load_motor(1, pins[1], pins[0], s);
    off_left = dur;
  endfunction

  function automatic void stop_all();
    load_motor(0, 1'b0, 1'b0, 16'sd0);
    load_motor(1, 1'b0, 1'b0, 16'sd0);
    held_move = MOVE_OFF;
    off_left  = '0;
  endfunction

  function automatic void tick_ms();
    if (off_left != 0) begin
      off_left = off_left - 1'b1;
      if (off_left == 0) stop_all();
    end
    for (int m = 0; m < 2; m++) begin
      if (blink_left[m] != 0) begin
        blink_left[m] = blink_left[m] - 1'b1;
        if (blink_left[m] == 0) begin
          drive_on[m]   = ~drive_on[m];
          blink_left[m] = blink_reload();
        end
      end
    end
  endfunction

  function automatic out_word_t run_command(in_word_t w);
    out_word_t  r;
    logic [7:0] a [2];
    logic [7:0] b [2];
    logic [7:0] e [2];
    case (w.action)
      ACT_TICK:    tick_ms();
      ACT_MOVE:    start_move(w.move_kind, w.speed, w.duration_ms);
      ACT_OFF:     stop_all();
      ACT_UPDATE:  start_move(held_move, w.speed, 16'd0);
      ACT_REAPPLY: start_move(held_move, held_speed, 16'd0);
      default: ;
    endcase
    for (int m = 0; m < 2; m++) begin
      a[m] = ahead_lvl[m];
      b[m] = back_lvl[m];
      e[m] = enable_lvl[m];
      // brake blink off phase
      if (!drive_on[m]) begin
        if (enable_mode[m]) begin
          e[m] = 8'd0;
        end else begin
          a[m] = 8'd0;
          b[m] = 8'd0;
        end
      end
    end
    r.left_ahead   = a[0];
    r.left_back    = b[0];
    r.left_enable  = e[0];
    r.right_ahead  = a[1];
    r.right_back   = b[1];
    r.right_enable = e[1];
    r.moving       = active[0] | active[1];
    r.current_move = held_move;
    return r;
  endfunction

  function automatic bit field_bad(string name, int unsigned want, int unsigned got);
    if (want == got) return 1'b0;
    if (mismatches < 10) begin
      $display("result %0d: %s expected %0d got %0d", results_seen, name, want, got);
    end
    return 1'b1;
  endfunction

  function automatic void check_word(out_word_t got);
    out_word_t want;
    bit        bad;
    if (lines_due.size() == 0) begin
      if (mismatches < 10) begin
        $display("result %0d: unexpected word %h", results_seen, got);
      end
      mismatches++;
    end else begin
      want = lines_due.pop_front();
      bad = 1'b0;
      bad |= field_bad("left_ahead", want.left_ahead, got.left_ahead);
      bad |= field_bad("left_back", want.left_back, got.left_back);
      bad |= field_bad("left_enable", want.left_enable, got.left_enable);
      bad |= field_bad("right_ahead", want.right_ahead, got.right_ahead);
      bad |= field_bad("right_back", want.right_back, got.right_back);
      bad |= field_bad("right_enable", want.right_enable, got.right_enable);
      bad |= field_bad("moving", want.moving, got.moving);
      bad |= field_bad("current_move", want.current_move, got.current_move);
      if (bad) mismatches++;
    end
    results_seen++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      lines_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEFT_RATIO:  ratio[0]       = cfg_data[11:0];
          CFG_RIGHT_RATIO: ratio[1]       = cfg_data[11:0];
          CFG_LEFT_MODE:   enable_mode[0] = cfg_data[0];
          CFG_RIGHT_MODE:  enable_mode[1] = cfg_data[0];
          CFG_BLINK:       blink_period   = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_word(out_data);
      if (in_valid && in_ready) lines_due.push_back(run_command(in_data));
    end
    awaited <= lines_due.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// top of the move controller testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import dhb_pkg::*;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_word_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int mismatches;
  int awaited;
  int words_sent = 0;
  int reg_writes = 0;
  bit steady     = 1'b0;

  dual_h_bridge_move_controller_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dhb_move_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 17);
  end

  task automatic send_word(logic [2:0] act, logic [3:0] kind, logic signed [15:0] spd,
                           logic [15:0] dur);
    in_word_t w;
    w.action      = act;
    w.move_kind   = kind;
    w.speed       = spd;
    w.duration_ms = dur;
    if (!steady && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 17);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    // the checker's outstanding count settles after the edge
    @(negedge clk);
    while (awaited != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  task automatic set_regs(logic [11:0] l_ratio, logic [11:0] r_ratio, logic l_mode,
                          logic r_mode, logic [15:0] blink);
    write_reg(CFG_LEFT_RATIO, {4'd0, l_ratio});
    write_reg(CFG_RIGHT_RATIO, {4'd0, r_ratio});
    write_reg(CFG_LEFT_MODE, {15'd0, l_mode});
    write_reg(CFG_RIGHT_MODE, {15'd0, r_mode});
    write_reg(CFG_BLINK, blink);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_word();
    int          pick;
    int          sel;
    logic [2:0]  act;
    logic [3:0]  kind;
    logic signed [15:0] spd;
    logic [15:0] dur;
    pick = $urandom_range(99);
    if (pick < 45)      act = ACT_TICK;
    else if (pick < 70) act = ACT_MOVE;
    else if (pick < 77) act = ACT_OFF;
    else if (pick < 87) act = ACT_UPDATE;
    else if (pick < 95) act = ACT_REAPPLY;
    else                act = 3'($urandom_range(7, 5));
    kind = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(11));
    sel = $urandom_range(9);
    if (sel < 5)       spd = 16'(int'($urandom_range(450)) - 50);
    else if (sel == 5) spd = ($urandom_range(1) == 0) ? 16'sh8000 : 16'sh7fff;
    else if (sel < 8)  spd = 16'($urandom);
    else               spd = 16'(int'($urandom_range(600)) - 300);
    sel = $urandom_range(9);
    if (sel < 5)      dur = 16'd0;
    else if (sel < 9) dur = 16'($urandom_range(12, 1));
    else              dur = 16'($urandom);
    send_word(act, kind, spd, dur);
  endtask

  initial begin
    logic signed [15:0] speeds [16];
    speeds = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd255, 16'sd256, 16'sd1, -16'sd1,
               16'sd1000, 16'sd500, 16'sd300, 16'sd20000, -16'sd5, 16'sd100,
               16'sd77, 16'sd12345, 16'sd999};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: every move kind, speed extremes, timeout expiry
    send_word(ACT_TICK, 4'd0, 16'sd0, 16'd0);
    for (int k = 0; k < 16; k++) begin
      send_word(ACT_MOVE, 4'(k), speeds[k], (k == 1) ? 16'hffff : 16'd0);
    end
    send_word(ACT_UPDATE, 4'd0, 16'sd128, 16'd0);
    send_word(ACT_REAPPLY, 4'd0, 16'sd0, 16'd0);
    send_word(3'd5, 4'hf, 16'shffff, 16'hffff);
    send_word(3'd7, 4'd0, 16'sd0, 16'd0);
    send_word(ACT_MOVE, 4'd3, 16'sd200, 16'd2);
    send_word(ACT_TICK, 4'd0, 16'sd0, 16'd0);
    send_word(ACT_TICK, 4'd0, 16'sd0, 16'd0);
    send_word(ACT_OFF, 4'd5, 16'sd40, 16'd9);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      steady = (ph == 3);
      case (ph)
        0: set_regs(12'd0, 12'd4000, 1'b0, 1'b1, 16'd1);
        1: set_regs(12'd4000, 12'd0, 1'b1, 1'b0, 16'd0);
        2: set_regs(12'd1000, 12'd1000, 1'b0, 1'b0, 16'hffff);
        3: set_regs(12'd1, 12'd3999, 1'b1, 1'b1, 16'd2);
        default: set_regs(12'($urandom_range(4000)), 12'($urandom_range(4000)),
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          16'($urandom_range(6, 1)));
      endcase
      repeat (168) random_word();
    end
    steady = 1'b0;
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d command and tick words under 9 register settings", words_sent);
    $display("%0d register writes, %0d mismatching result words", reg_writes, mismatches);
    if (mismatches == 0 && awaited == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d result words outstanding", awaited);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
